// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned DEPTH_DEFAULT     = 16;
    localparam int unsigned PRIO_BITS_DEFAULT = 16;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned PRIO_REQ_W = 16;
    localparam int unsigned OCC_W      = 5;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 104;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_spq_ctrl;

endpackage

// File: hdl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, shifts right on insert, shifts left
// on removal.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spq_pkg::t_spq_ctrl          i_ctrl,
    input  logic [spq_pkg::VALUE_W-1:0] i_new_value,
    input  logic [PRIO_BITS-1:0]        i_new_prio,
    input  logic                        i_left_valid,
    input  logic [spq_pkg::VALUE_W-1:0] i_left_value,
    input  logic [PRIO_BITS-1:0]        i_left_prio,
    input  logic                        i_left_keep,
    input  logic                        i_right_valid,
    input  logic [spq_pkg::VALUE_W-1:0] i_right_value,
    input  logic [PRIO_BITS-1:0]        i_right_prio,
    output logic                        o_valid,
    output logic [spq_pkg::VALUE_W-1:0] o_value,
    output logic [PRIO_BITS-1:0]        o_prio,
    output logic                        o_keep,
    output logic                        o_n_valid,
    output logic [spq_pkg::VALUE_W-1:0] o_n_value,
    output logic [PRIO_BITS-1:0]        o_n_prio
);
    import spq_pkg::*;

    logic                 r_valid;
    logic [VALUE_W-1:0]   r_value;
    logic [PRIO_BITS-1:0] r_prio;
    logic                 n_valid;
    logic [VALUE_W-1:0]   n_value;
    logic [PRIO_BITS-1:0] n_prio;
    logic                 keep;

    assign keep = r_valid && (r_prio <= i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.enq && !keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end else begin
                n_valid = i_left_valid;
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end
        end else if (i_ctrl.deq) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_prio    = r_prio;
    assign o_keep    = keep;
    assign o_n_valid = n_valid;
    assign o_n_value = n_value;
    assign o_n_prio  = n_prio;

endmodule

// File: hdl/stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded, stable priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one operation per transaction: tuser selects
//   enqueue (0) or dequeue (1); tdata carries the value and the priority.
//   Lower priority numbers leave first; equal priorities leave in arrival
//   order. Every operation yields exactly one result transaction on the
//   master channel: tuser holds the status (ok, overflow, underflow) and
//   tdata the removed entry, the new head and the occupancy.
//   The result is registered; it is valid in the cycle after acceptance.
//   Throughput: one operation per cycle unless stalled; all cells compare
//   against the new priority at once, shifting to a neighbor in the same cycle.
//   The result register frees in the cycle the receiver takes it, so a new
//   operation is taken while the previous result is being consumed.
//   Stall: while a result waits with tready low, s_axis tready drops and
//   the cells hold.
//   Reset: synchronous, active low; clears every cell's valid bit (queue
//   empty), the occupancy and the result valid flag. No clearing pass is
//   needed.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEFAULT,
    parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [31:0] value, [47:32] priority_req
    input  logic [spq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] opcode
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] removed_valid, [32:1] removed_value, [48:33] removed_priority,
    // [49] head_valid, [81:50] head_value, [97:82] head_priority,
    // [102:98] occupancy, [103] zero
    output logic [spq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [spq_pkg::STATUS_W-1:0]   o_m_axis_tuser
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                 accept;
    logic                 full;
    logic                 empty;
    t_opcode              op;
    logic [VALUE_W-1:0]   in_value;
    logic [PRIO_BITS-1:0] in_prio;
    logic [PRIO_BITS+PRIO_REQ_W-1:0] in_prio_ext;
    t_spq_ctrl            ctrl;

    logic [DEPTH-1:0]     c_valid;
    logic [DEPTH-1:0]     c_keep;
    logic [DEPTH-1:0]     c_n_valid;
    logic [VALUE_W-1:0]   c_value   [DEPTH];
    logic [PRIO_BITS-1:0] c_prio    [DEPTH];
    logic [VALUE_W-1:0]   c_n_value [DEPTH];
    logic [PRIO_BITS-1:0] c_n_prio  [DEPTH];

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW+OCC_W-1:0]  count_ext;
    logic [PRIO_BITS+PRIO_REQ_W-1:0] head_prio_ext;
    logic [PRIO_BITS+PRIO_REQ_W-1:0] rem_prio_ext;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0]   r_out_status;
    logic [OUT_DATA_W-1:0] n_out_data;
    t_status               n_status;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign op          = t_opcode'(i_s_axis_tuser);
    assign in_value    = i_s_axis_tdata[VALUE_W-1:0];
    assign in_prio_ext = {{PRIO_BITS{1'b0}}, i_s_axis_tdata[VALUE_W +: PRIO_REQ_W]};
    assign in_prio     = in_prio_ext[PRIO_BITS-1:0];

    assign full  = c_valid[DEPTH-1];
    assign empty = !c_valid[0];

    assign ctrl.enq = accept && (op == OP_ENQUEUE) && !full;
    assign ctrl.deq = accept && (op == OP_DEQUEUE) && !empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 left_valid;
        logic [VALUE_W-1:0]   left_value;
        logic [PRIO_BITS-1:0] left_prio;
        logic                 left_keep;
        logic                 right_valid;
        logic [VALUE_W-1:0]   right_value;
        logic [PRIO_BITS-1:0] right_prio;

        if (g == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_value = '0;
            assign left_prio  = '0;
            assign left_keep  = 1'b1;
        end else begin : g_mid
            assign left_valid = c_valid[g-1];
            assign left_value = c_value[g-1];
            assign left_prio  = c_prio[g-1];
            assign left_keep  = c_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_value = '0;
            assign right_prio  = '0;
        end else begin : g_body
            assign right_valid = c_valid[g+1];
            assign right_value = c_value[g+1];
            assign right_prio  = c_prio[g+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_new_value   (in_value),
            .i_new_prio    (in_prio),
            .i_left_valid  (left_valid),
            .i_left_value  (left_value),
            .i_left_prio   (left_prio),
            .i_left_keep   (left_keep),
            .i_right_valid (right_valid),
            .i_right_value (right_value),
            .i_right_prio  (right_prio),
            .o_valid       (c_valid[g]),
            .o_value       (c_value[g]),
            .o_prio        (c_prio[g]),
            .o_keep        (c_keep[g]),
            .o_n_valid     (c_n_valid[g]),
            .o_n_value     (c_n_value[g]),
            .o_n_prio      (c_n_prio[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctrl.enq) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    assign count_ext     = {{OCC_W{1'b0}}, n_count};
    assign head_prio_ext = {{PRIO_REQ_W{1'b0}}, c_n_prio[0]};
    assign rem_prio_ext  = {{PRIO_REQ_W{1'b0}}, c_prio[0]};

    always_comb begin
        n_status = STATUS_OK;
        if (op == OP_ENQUEUE && full) begin
            n_status = STATUS_OVERFLOW;
        end else if (op == OP_DEQUEUE && empty) begin
            n_status = STATUS_UNDERFLOW;
        end
        n_out_data          = '0;
        n_out_data[0]       = ctrl.deq;
        n_out_data[32:1]    = ctrl.deq ? c_value[0] : '0;
        n_out_data[48:33]   = ctrl.deq ? rem_prio_ext[PRIO_REQ_W-1:0] : '0;
        n_out_data[49]      = c_n_valid[0];
        n_out_data[81:50]   = c_n_valid[0] ? c_n_value[0] : '0;
        n_out_data[97:82]   = c_n_valid[0] ? head_prio_ext[PRIO_REQ_W-1:0] : '0;
        n_out_data[102:98]  = count_ext[OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTH
    a_count_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == c_valid[0])
        else $error("occupancy and head valid disagree");

    a_count_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(DEPTH)) == c_valid[DEPTH-1])
        else $error("occupancy and tail valid disagree");

    a_one_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.enq, ctrl.deq}))
        else $error("enqueue and dequeue in the same cycle");

    a_underflow_none : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_UNDERFLOW) |-> !r_out_data[0])
        else $error("underflow result reports a removed entry");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("occupancy moved without a transaction");
`endif

endmodule

// File: bench/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking bench for the stable priority queue. A sorted-store
// predictor tracks every accepted operation and each result transaction is
// compared field by field against the oldest prediction. Covers extremes,
// fill and overflow, drain and underflow, random mixes with random idling,
// and a long receiver hold-off that stalls the input side.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int unsigned QDEPTH      = DEPTH_DEFAULT;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        t_status                status;
        logic                   rem_valid;
        logic [VALUE_W-1:0]     rem_value;
        logic [PRIO_REQ_W-1:0]  rem_prio;
        logic                   head_valid;
        logic [VALUE_W-1:0]     head_value;
        logic [PRIO_REQ_W-1:0]  head_prio;
        logic [OCC_W-1:0]       occupancy;
    } t_spq_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]   o_m_axis_tuser;

    stable_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: sorted store, slot 0 is the head
    logic [VALUE_W-1:0]    held_value [QDEPTH];
    logic [PRIO_REQ_W-1:0] held_prio  [QDEPTH];
    int unsigned           held_count = 0;
    t_spq_result           pending_results [$];

    bit          src_idle    = 1'b0;
    bit          sink_idle   = 1'b0;
    bit          hold_output = 1'b0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_enq = 0, n_deq = 0, n_over = 0, n_under = 0, n_results = 0;

    function automatic void predict_op(t_opcode op, logic [VALUE_W-1:0] val,
                                       logic [PRIO_REQ_W-1:0] prio);
        t_spq_result r;
        int unsigned pos;
        r = '0;
        r.status = STATUS_OK;
        if (op == OP_ENQUEUE) begin
            if (held_count >= QDEPTH) begin
                r.status = STATUS_OVERFLOW;
                n_over++;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio) pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[pos] = val;
                held_prio[pos]  = prio;
                held_count++;
                n_enq++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = STATUS_UNDERFLOW;
                n_under++;
            end else begin
                r.rem_valid = 1'b1;
                r.rem_value = held_value[0];
                r.rem_prio  = held_prio[0];
                for (int i = 0; i + 1 < held_count; i++) begin
                    held_value[i] = held_value[i+1];
                    held_prio[i]  = held_prio[i+1];
                end
                held_count--;
                n_deq++;
            end
        end
        if (held_count > 0) begin
            r.head_valid = 1'b1;
            r.head_value = held_value[0];
            r.head_prio  = held_prio[0];
        end
        r.occupancy = held_count[OCC_W-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic send_op(t_opcode op, logic [VALUE_W-1:0] val,
                           logic [PRIO_REQ_W-1:0] prio);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {prio, val};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_op(op, val, prio);
    endtask

    function automatic logic [PRIO_REQ_W-1:0] draw_priority();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0, 1: return PRIO_REQ_W'($urandom_range(0, 7));
            2: return PRIO_REQ_W'($urandom);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    task automatic send_random(int unsigned enq_pct);
        if ($urandom_range(0, 99) < enq_pct)
            send_op(OP_ENQUEUE, $urandom, draw_priority());
        else
            send_op(OP_DEQUEUE, $urandom, PRIO_REQ_W'($urandom));
    endtask

    // result channel acceptor
    initial begin
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                stall = sink_idle ? $urandom_range(0, 8) : 0;
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
                do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_spq_result got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            got.status     = t_status'(o_m_axis_tuser);
            got.rem_valid  = o_m_axis_tdata[0];
            got.rem_value  = o_m_axis_tdata[32:1];
            got.rem_prio   = o_m_axis_tdata[48:33];
            got.head_valid = o_m_axis_tdata[49];
            got.head_value = o_m_axis_tdata[81:50];
            got.head_prio  = o_m_axis_tdata[97:82];
            got.occupancy  = o_m_axis_tdata[102:98];
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result transaction %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.status     !== want.status     ||
                    got.rem_valid  !== want.rem_valid  ||
                    got.rem_value  !== want.rem_value  ||
                    got.rem_prio   !== want.rem_prio   ||
                    got.head_valid !== want.head_valid ||
                    got.head_value !== want.head_value ||
                    got.head_prio  !== want.head_prio  ||
                    got.occupancy  !== want.occupancy) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("ERROR: result %0d differs", n_results);
                        $display("  expected %p", want);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("stable_priority_queue: mismatch");
            $finish;
        end
    end

    task automatic test_extremes();
        send_op(OP_DEQUEUE, 32'h0000_0000, 16'h0000);
        send_op(OP_ENQUEUE, 32'h0000_0000, 16'h0000);
        send_op(OP_ENQUEUE, 32'h7FFF_FFFF, 16'hFFFF);
        send_op(OP_ENQUEUE, 32'h8000_0000, 16'h0000);
        send_op(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(OP_ENQUEUE, 32'h5555_5555, 16'h8000);
        send_op(OP_ENQUEUE, 32'hAAAA_AAAA, 16'h7FFF);
        send_op(OP_ENQUEUE, 32'h0000_0001, 16'h0000);
        repeat (7) send_op(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(OP_DEQUEUE, 32'h1234_5678, 16'hFFFF);
    endtask

    task automatic test_fill_overflow(int unsigned rounds);
        repeat (rounds) begin
            src_idle  = $urandom_range(0, 1);
            sink_idle = $urandom_range(0, 1);
            while (held_count < QDEPTH) send_op(OP_ENQUEUE, $urandom, draw_priority());
            repeat ($urandom_range(1, 3)) send_op(OP_ENQUEUE, $urandom, draw_priority());
            while (held_count > 0) send_op(OP_DEQUEUE, $urandom, PRIO_REQ_W'($urandom));
            send_op(OP_DEQUEUE, $urandom, PRIO_REQ_W'($urandom));
        end
    endtask

    task automatic test_backpressure();
        src_idle    = 1'b0;
        sink_idle   = 1'b0;
        hold_output = 1'b1;
        repeat (40) send_random(60);
    endtask

    task automatic test_random_mix(int unsigned phases, int unsigned per_phase);
        int unsigned bias;
        repeat (phases) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 2))
                0: bias = 30;
                1: bias = 50;
                default: bias = 75;
            endcase
            repeat (per_phase) send_random(bias);
        end
    endtask

    initial begin
        int unsigned waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_fill_overflow(3);
        test_backpressure();
        test_random_mix(10, 50);

        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            error_count += pending_results.size();
            $display("ERROR: %0d results never arrived", pending_results.size());
        end

        $display("covered %0d enqueues, %0d dequeues, %0d overflows, %0d underflows",
                 n_enq, n_deq, n_over, n_under);
        $display("checked %0d result transactions, %0d errors", n_results, error_count);
        if (error_count == 0)
            $display("stable_priority_queue: match");
        else
            $display("stable_priority_queue: mismatch");
        $finish;
    end

endmodule

// File: stable_priority_queue.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
bench/tb_stable_priority_queue.sv
